[sv/readout_word_stream_deframer_assert.svh]
// Assertion macros for the readout word stream deframer.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef READOUT_WORD_STREAM_DEFRAMER_ASSERT_SVH
`define READOUT_WORD_STREAM_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define RWSD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define RWSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RWSD_ASSERT_IMPLY(label, ante, cons, msg)

`define RWSD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/rwsd_pkg.sv]
package rwsd_pkg;

   localparam logic [1:0] KIND_HIT   = 2'd0;
   localparam logic [1:0] KIND_CLEAN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_EARLY  = 2'd0;
   localparam logic [1:0] ERR_HEADER = 2'd1;
   localparam logic [1:0] ERR_ID     = 2'd2;
   localparam logic [1:0] ERR_PAD    = 2'd3;

   localparam logic [7:0] TOP_END_HEADER  = 8'haf;
   localparam logic [7:0] TOP_CTRL_HEADER = 8'hab;
   localparam logic [3:0] NIB_CARD        = 4'hc;
   localparam logic [3:0] NIB_DATA        = 4'h0;
   localparam logic [3:0] CTRL_ID_FIRST   = 4'd1;
   localparam logic [3:0] CTRL_ID_SECOND  = 4'd2;

   typedef struct packed {
      logic [15:0] word;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] error_code;
      logic       ccb_index;
      logic [7:0] wire_res;
      logic [7:0] value;
   } rsp_type;

endpackage

[sv/readout_word_stream_deframer.sv]
// Readout word stream deframer.
// The request channel (req_valid, req_stall, req_data) carries one 16-bit readout
// word per request with a flag that marks the last word of a buffer. The block
// parses controller headers, end headers, card headers, data words, trailers and
// pad words, and returns at most one response per request on the response channel
// (rsp_valid, rsp_stall, rsp_data): a hit for each data word that is not the last
// word, a clean-end report when a buffer ends on a complete block, or an error
// report. Each request is parsed in the cycle it is accepted; its response is
// registered and shows on rsp_data. One request is taken every cycle as long as
// the receiver keeps up, so the throughput is one word per cycle.
// When the receiver stalls, the output register holds its response and a one-entry
// skid register catches the response of the request taken in that cycle; req_stall
// rises only while the skid register is full, and it is driven from a register.
// After an error the parser ignores words up to the last word of the buffer, which
// produces no response, and then starts over with the next buffer.
// Reset is synchronous and active high; it empties both output registers and puts
// the parser at the start of a buffer, expecting a block header.
`include "readout_word_stream_deframer_assert.svh"

module readout_word_stream_deframer
   import rwsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [9:0] {
      PH_HDR0   = 10'b00_0000_0001,
      PH_HDR    = 10'b00_0000_0010,
      PH_BADHDR = 10'b00_0000_0100,
      PH_BODY   = 10'b00_0000_1000,
      PH_CARD   = 10'b00_0001_0000,
      PH_DATA   = 10'b00_0010_0000,
      PH_TRL0   = 10'b00_0100_0000,
      PH_TRL1   = 10'b00_1000_0000,
      PH_PAD    = 10'b01_0000_0000,
      PH_ERR    = 10'b10_0000_0000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] skip_ff, skip_in;
   logic       ccb_ff, ccb_in;
   logic [3:0] card_ff, card_in;
   logic       is_end_ff, is_end_in;
   logic       pad_ff, pad_in;

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   rsp_type    skid_data_ff, skid_data_in;

   logic       req_accept;
   logic       out_take;
   logic       last;
   logic [15:0] w;
   logic [3:0] nib;
   logic [3:0] id;
   logic       do_fail;
   logic [1:0] fail_code;
   logic       do_done;
   logic       do_restart;
   logic       res_valid;
   rsp_type    res;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_take   = out_valid_ff && !rsp_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   assign w    = req_data.word;
   assign last = req_data.last_word;
   assign nib  = w[15:12];
   assign id   = w[11:8];

   always_comb begin
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      ccb_in     = ccb_ff;
      card_in    = card_ff;
      is_end_in  = is_end_ff;
      pad_in     = pad_ff;
      do_fail    = 1'b0;
      fail_code  = ERR_EARLY;
      do_done    = 1'b0;
      do_restart = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      if (req_accept) begin
         case (phase_ff)
            PH_HDR0: begin
               if (last) begin
                  do_fail = 1'b1;
               end else begin
                  skip_in = 2'd1;
                  if (w[15:8] == TOP_END_HEADER) begin
                     is_end_in = 1'b1;
                     phase_in  = PH_HDR;
                  end else if (w[15:8] == TOP_CTRL_HEADER) begin
                     is_end_in = 1'b0;
                     phase_in  = PH_HDR;
                  end else begin
                     phase_in = PH_BADHDR;
                  end
               end
            end
            PH_BADHDR: begin
               if (skip_ff == 2'd3) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_HEADER;
               end else if (last) begin
                  do_fail = 1'b1;
               end else begin
                  skip_in = skip_ff + 2'd1;
               end
            end
            PH_HDR: begin
               if (last) begin
                  do_fail = 1'b1;
               end else if (skip_ff == 2'd2 && !is_end_ff &&
                            id != CTRL_ID_FIRST && id != CTRL_ID_SECOND) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_ID;
               end else begin
                  if (skip_ff == 2'd2 && !is_end_ff) begin
                     ccb_in = (id == CTRL_ID_SECOND);
                  end
                  if (skip_ff == 2'd3) begin
                     skip_in  = 2'd0;
                     phase_in = is_end_ff ? PH_TRL0 : PH_BODY;
                  end else begin
                     skip_in = skip_ff + 2'd1;
                  end
               end
            end
            PH_CARD: begin
               if (last) begin
                  do_fail = 1'b1;
               end else begin
                  if (skip_ff == 2'd2) begin
                     card_in = id;
                  end
                  if (skip_ff == 2'd3) begin
                     skip_in  = 2'd0;
                     phase_in = PH_DATA;
                  end else begin
                     skip_in = skip_ff + 2'd1;
                  end
               end
            end
            PH_BODY, PH_DATA, PH_TRL0: begin
               if (phase_ff == PH_DATA && nib == NIB_DATA) begin
                  if (last) begin
                     do_fail = 1'b1;
                  end else begin
                     res_valid      = 1'b1;
                     res.kind       = KIND_HIT;
                     res.ccb_index  = ccb_ff;
                     res.wire_res   = {card_ff, id};
                     res.value      = w[7:0];
                  end
               end else if (phase_ff != PH_TRL0 && nib == NIB_CARD) begin
                  if (last) begin
                     do_fail = 1'b1;
                  end else begin
                     skip_in  = 2'd1;
                     phase_in = PH_CARD;
                  end
               end else begin
                  pad_in = w[0];
                  if (last) begin
                     do_fail = 1'b1;
                  end else begin
                     phase_in = PH_TRL1;
                  end
               end
            end
            PH_TRL1: begin
               if (pad_ff) begin
                  if (last) begin
                     do_fail = 1'b1;
                  end else begin
                     phase_in = PH_PAD;
                  end
               end else begin
                  do_done = 1'b1;
               end
            end
            PH_PAD: begin
               if (w != 16'd0) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_PAD;
               end else begin
                  do_done = 1'b1;
               end
            end
            PH_ERR: begin
               do_restart = last;
            end
            default: begin
               do_restart = 1'b1;
            end
         endcase

         if (do_fail) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = fail_code;
            if (last) begin
               do_restart = 1'b1;
            end else begin
               phase_in = PH_ERR;
            end
         end
         if (do_done) begin
            do_restart = 1'b1;
            if (last) begin
               res_valid = 1'b1;
               res.kind  = KIND_CLEAN;
            end
         end
         if (do_restart) begin
            phase_in = PH_HDR0;
            skip_in  = 2'd0;
            pad_in   = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         skip_ff       <= 2'd0;
         ccb_ff        <= 1'b0;
         card_ff       <= 4'd0;
         is_end_ff     <= 1'b0;
         pad_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         skip_ff       <= skip_in;
         ccb_ff        <= ccb_in;
         card_ff       <= card_in;
         is_end_ff     <= is_end_in;
         pad_ff        <= pad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   `RWSD_ASSERT_IMPLY(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full while output empty")
   `RWSD_ASSERT_NEXT(a_last_restarts, req_accept && last, phase_ff == PH_HDR0 && skip_ff == 2'd0 && !pad_ff, "parser did not restart after last word")
   `RWSD_ASSERT_IMPLY(a_last_reports, req_accept && last && phase_ff != PH_ERR, res_valid, "last word gave no report")
   `RWSD_ASSERT_IMPLY(a_err_silent, req_accept && phase_ff == PH_ERR, !res_valid, "response while skipping after error")

endmodule

[test/tb_readout_word_stream_deframer.sv]
`timescale 1ns / 1ps

module tb_readout_word_stream_deframer;
   import rwsd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int WORD_TARGET = 1900;
   localparam int HOLD_AFTER  = 600;
   localparam int HOLD_CYCLES = 150;
   localparam int CALM_WORDS  = 250;

   typedef enum logic [9:0] {
      ST_HEAD0   = 10'b00_0000_0001,
      ST_HEAD    = 10'b00_0000_0010,
      ST_BADHEAD = 10'b00_0000_0100,
      ST_BODY    = 10'b00_0000_1000,
      ST_CARD    = 10'b00_0001_0000,
      ST_DATA    = 10'b00_0010_0000,
      ST_TRAIL0  = 10'b00_0100_0000,
      ST_TRAIL1  = 10'b00_1000_0000,
      ST_PAD     = 10'b01_0000_0000,
      ST_SKIP    = 10'b10_0000_0000
   } parse_state_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type     word_queue[$];
   rsp_type     expected_reports[$];
   logic [15:0] frame[$];

   parse_state_type st = ST_HEAD0;
   logic [1:0]      hdr_index = 2'd0;
   logic            cur_ccb = 1'b0;
   logic [3:0]      cur_card = 4'd0;
   logic            end_block = 1'b0;
   logic            pad_pending = 1'b0;

   int   n_accepted = 0;
   int   calm_point = 0;
   int   n_fail = 0;
   int   n_hits = 0;
   int   n_clean = 0;
   int   n_errors = 0;
   int   cycles = 0;
   int   send_idle = 0;
   int   recv_idle = 0;
   int   hold_left = 0;
   bit   hold_done = 0;
   logic hold_on = 1'b0;

   readout_word_stream_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void restart_parser();
      st = ST_HEAD0;
      hdr_index = 2'd0;
      pad_pending = 1'b0;
   endfunction

   function automatic bit report_error(input logic [1:0] code, input logic last,
                                       output rsp_type res);
      res = '0;
      res.kind = KIND_ERROR;
      res.error_code = code;
      if (last) begin
         restart_parser();
      end else begin
         st = ST_SKIP;
      end
      return 1'b1;
   endfunction

   function automatic bit finish_block(input logic last, output rsp_type res);
      res = '0;
      restart_parser();
      if (last) begin
         res.kind = KIND_CLEAN;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit start_card(input logic last, output rsp_type res);
      res = '0;
      if (last) return report_error(ERR_EARLY, 1'b1, res);
      hdr_index = 2'd1;
      st = ST_CARD;
      return 1'b0;
   endfunction

   function automatic bit start_trailer(input logic [15:0] w, input logic last,
                                        output rsp_type res);
      res = '0;
      pad_pending = w[0];
      if (last) return report_error(ERR_EARLY, 1'b1, res);
      st = ST_TRAIL1;
      return 1'b0;
   endfunction

   // Advances the parser by one word and returns 1 when the word yields a report.
   function automatic bit parse_word(input req_type r, output rsp_type res);
      logic [15:0] w;
      logic        last;
      logic [3:0]  nib;
      bit          got;
      w = r.word;
      last = r.last_word;
      nib = w[15:12];
      got = 1'b0;
      res = '0;
      case (st)
         ST_HEAD0: begin
            if (last) begin
               got = report_error(ERR_EARLY, 1'b1, res);
            end else begin
               hdr_index = 2'd1;
               if (w[15:8] == TOP_END_HEADER) begin
                  end_block = 1'b1;
                  st = ST_HEAD;
               end else if (w[15:8] == TOP_CTRL_HEADER) begin
                  end_block = 1'b0;
                  st = ST_HEAD;
               end else begin
                  st = ST_BADHEAD;
               end
            end
         end
         ST_BADHEAD: begin
            if (hdr_index == 2'd3) got = report_error(ERR_HEADER, last, res);
            else if (last) got = report_error(ERR_EARLY, 1'b1, res);
            else hdr_index = hdr_index + 2'd1;
         end
         ST_HEAD: begin
            if (last) begin
               got = report_error(ERR_EARLY, 1'b1, res);
            end else if (hdr_index == 2'd2 && !end_block
                         && w[11:8] != CTRL_ID_FIRST && w[11:8] != CTRL_ID_SECOND) begin
               got = report_error(ERR_ID, 1'b0, res);
            end else begin
               if (hdr_index == 2'd2 && !end_block) cur_ccb = (w[11:8] == CTRL_ID_SECOND);
               if (hdr_index == 2'd3) begin
                  hdr_index = 2'd0;
                  st = end_block ? ST_TRAIL0 : ST_BODY;
               end else begin
                  hdr_index = hdr_index + 2'd1;
               end
            end
         end
         ST_BODY: begin
            if (nib == NIB_CARD) got = start_card(last, res);
            else got = start_trailer(w, last, res);
         end
         ST_CARD: begin
            if (last) begin
               got = report_error(ERR_EARLY, 1'b1, res);
            end else begin
               if (hdr_index == 2'd2) cur_card = w[11:8];
               if (hdr_index == 2'd3) begin
                  hdr_index = 2'd0;
                  st = ST_DATA;
               end else begin
                  hdr_index = hdr_index + 2'd1;
               end
            end
         end
         ST_DATA: begin
            if (nib == NIB_DATA) begin
               if (last) begin
                  got = report_error(ERR_EARLY, 1'b1, res);
               end else begin
                  got = 1'b1;
                  res.kind = KIND_HIT;
                  res.ccb_index = cur_ccb;
                  res.wire_res = {cur_card, w[11:8]};
                  res.value = w[7:0];
               end
            end else if (nib == NIB_CARD) begin
               got = start_card(last, res);
            end else begin
               got = start_trailer(w, last, res);
            end
         end
         ST_TRAIL0: got = start_trailer(w, last, res);
         ST_TRAIL1: begin
            if (pad_pending) begin
               if (last) got = report_error(ERR_EARLY, 1'b1, res);
               else st = ST_PAD;
            end else begin
               got = finish_block(last, res);
            end
         end
         ST_PAD: begin
            if (w != 16'h0000) got = report_error(ERR_PAD, last, res);
            else got = finish_block(last, res);
         end
         default: begin
            if (last) restart_parser();
         end
      endcase
      return got;
   endfunction

   task automatic send_frame(input int cut);
      req_type r;
      for (int i = 0; i <= cut; i++) begin
         r.word = frame[i];
         r.last_word = (i == cut);
         word_queue.push_back(r);
      end
      frame.delete();
   endtask

   task automatic add_trailer();
      logic [15:0] w;
      logic [15:0] second;
      do w = 16'($urandom); while (w[15:12] == NIB_DATA || w[15:12] == NIB_CARD);
      second = 16'($urandom);
      frame.push_back(w);
      frame.push_back(second);
      if (w[0]) begin
         if ($urandom_range(0, 7) == 0) second = 16'($urandom_range(1, 65535));
         else second = 16'h0000;
         frame.push_back(second);
      end
   endtask

   task automatic add_ctrl_block();
      logic [15:0] w;
      logic [3:0]  id;
      int          n_cards;
      int          n_data;
      w = 16'($urandom);
      frame.push_back({TOP_CTRL_HEADER, w[7:0]});
      w = 16'($urandom);
      frame.push_back(w);
      w = 16'($urandom);
      id = 4'($urandom_range(1, 2));
      frame.push_back({w[15:12], id, w[7:0]});
      w = 16'($urandom);
      frame.push_back(w);
      n_cards = $urandom_range(0, 3);
      for (int c = 0; c < n_cards; c++) begin
         w = 16'($urandom);
         frame.push_back({NIB_CARD, w[11:0]});
         for (int k = 0; k < 3; k++) begin
            w = 16'($urandom);
            frame.push_back(w);
         end
         n_data = $urandom_range(0, 6);
         for (int d = 0; d < n_data; d++) begin
            w = 16'($urandom);
            frame.push_back({NIB_DATA, w[11:0]});
         end
      end
      add_trailer();
   endtask

   task automatic add_end_block();
      logic [15:0] w;
      w = 16'($urandom);
      frame.push_back({TOP_END_HEADER, w[7:0]});
      for (int k = 0; k < 3; k++) begin
         w = 16'($urandom);
         frame.push_back(w);
      end
      add_trailer();
   endtask

   task automatic add_random_frame();
      logic [15:0] w;
      logic [3:0]  id;
      int          mode;
      int          n_blocks;
      n_blocks = $urandom_range(1, 3);
      for (int b = 0; b < n_blocks; b++) begin
         if ($urandom_range(0, 3) == 0) add_end_block();
         else add_ctrl_block();
      end
      mode = $urandom_range(0, 9);
      case (mode)
         6: send_frame(int'($urandom_range(0, frame.size() - 2)));
         7: begin
            w = 16'($urandom);
            frame[$urandom_range(0, frame.size() - 1)] = w;
            send_frame(frame.size() - 1);
         end
         8: begin
            if ($urandom_range(0, 1) == 0 || frame[0][15:8] != TOP_CTRL_HEADER) begin
               do w = 16'($urandom);
               while (w[15:8] == TOP_CTRL_HEADER || w[15:8] == TOP_END_HEADER);
               frame[0] = w;
            end else begin
               do id = 4'($urandom); while (id == CTRL_ID_FIRST || id == CTRL_ID_SECOND);
               frame[2][11:8] = id;
            end
            send_frame(frame.size() - 1);
         end
         9: begin
            frame.delete();
            for (int i = $urandom_range(1, 8); i > 0; i--) begin
               w = 16'($urandom);
               frame.push_back(w);
            end
            send_frame(frame.size() - 1);
         end
         default: send_frame(frame.size() - 1);
      endcase
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         n_fail++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type res;
      bit      go;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            if (parse_word(req_data, res)) expected_reports.push_back(res);
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            go = 1'b0;
            if (send_idle > 0) begin
               send_idle--;
            end else if (word_queue.size() > 0) begin
               if (n_accepted < calm_point && $urandom_range(0, 7) == 0) begin
                  send_idle = $urandom_range(0, 2);
               end else begin
                  go = 1'b1;
               end
            end
            req_valid <= go;
            if (go) req_data <= word_queue.pop_front();
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_on <= 1'b0;
      end else begin
         if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         hold_on <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      bit      stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected response: kind %0d", rsp_data.kind);
               n_fail++;
            end else begin
               want = expected_reports.pop_front();
               check_field("kind", 8'(want.kind), 8'(rsp_data.kind));
               check_field("error_code", 8'(want.error_code), 8'(rsp_data.error_code));
               check_field("ccb_index", 8'(want.ccb_index), 8'(rsp_data.ccb_index));
               check_field("wire_res", want.wire_res, rsp_data.wire_res);
               check_field("value", want.value, rsp_data.value);
               case (want.kind)
                  KIND_HIT: n_hits++;
                  KIND_CLEAN: n_clean++;
                  default: n_errors++;
               endcase
            end
         end
         if (hold_on) begin
            stall = 1'b1;
         end else if (recv_idle > 0) begin
            recv_idle--;
            stall = 1'b1;
         end else if (n_accepted < calm_point && $urandom_range(0, 7) == 0) begin
            recv_idle = $urandom_range(0, 2);
            stall = 1'b1;
         end else begin
            stall = 1'b0;
         end
         rsp_stall <= stall;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      // A full controller block with extreme hit fields, then a bad header
      // ending on its fourth word, an unknown controller id followed by
      // an ignored word, and a nonzero pad on the last word.
      frame = {16'hab00, 16'hffff, 16'h0200, 16'h0000, 16'hc000, 16'h0000,
               16'h0f00, 16'h0000, 16'h0fff, 16'h0000, 16'he001, 16'h0000,
               16'h0000};
      send_frame(frame.size() - 1);
      frame = {16'h7f00, 16'h0000, 16'h0000, 16'h0000};
      send_frame(frame.size() - 1);
      frame = {16'hab00, 16'h0000, 16'h0f00, 16'h0000};
      send_frame(frame.size() - 1);
      frame = {16'haf00, 16'h0000, 16'h0000, 16'h0000, 16'h1001, 16'h0000,
               16'h8000};
      send_frame(frame.size() - 1);

      while (word_queue.size() < WORD_TARGET) add_random_frame();
      calm_point = word_queue.size() - CALM_WORDS;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (word_queue.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Parsed %0d words into %0d hits, %0d clean buffer ends and %0d error reports,",
               n_accepted, n_hits, n_clean, n_errors);
      $display("with random gaps on both sides and one long response hold-off.");
      if (n_fail == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/rwsd_pkg.sv
sv/readout_word_stream_deframer.sv
test/tb_readout_word_stream_deframer.sv
